@@ hdl/voxel_to_occupancy_grid_projection_defines.svh @@
// ============================================================================
// Assertion macros for the occupancy grid projection block
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ============================================================================
`ifndef VOXEL_TO_OCCUPANCY_GRID_PROJECTION_DEFINES_SVH
`define VOXEL_TO_OCCUPANCY_GRID_PROJECTION_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define VOGP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define VOGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/vogp_pkg.sv @@
// ============================================================================
// Occupancy grid projection package
// Cell codes, cell values, item functions, result status codes and
// configuration register indexes.
// ============================================================================
package vogp_pkg;

    // Stored cell codes
    localparam logic [1:0] CODE_FREE    = 2'd0;
    localparam logic [1:0] CODE_UNKNOWN = 2'd1;
    localparam logic [1:0] CODE_OCC     = 2'd2;

    // Cell values as reported
    localparam logic signed [7:0] VAL_FREE    = 8'sd0;
    localparam logic signed [7:0] VAL_UNKNOWN = -8'sd1;
    localparam logic signed [7:0] VAL_OCC     = 8'sd100;

    // Item functions
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_VOXEL = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HEIGHT  = 2'd1;
    localparam logic [1:0] ST_WINDOW  = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd2;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd3;
    localparam logic [2:0] REG_Z_LOW       = 3'd4;
    localparam logic [2:0] REG_Z_HIGH      = 3'd5;
    localparam logic [2:0] REG_Z_MODE      = 3'd6;
    localparam logic [2:0] REG_UNKNOWN_DEF = 3'd7;

    localparam logic [12:0] COUNT_MAX = 13'd8191;

    // Map a stored code to its reported value; the spare code reads as free.
    function automatic logic signed [7:0] code_to_value(input logic [1:0] code);
        logic signed [7:0] val;
        unique case (code)
            CODE_OCC:     val = VAL_OCC;
            CODE_UNKNOWN: val = VAL_UNKNOWN;
            default:      val = VAL_FREE;
        endcase
        return val;
    endfunction

endpackage

@@ hdl/vogp_ram.sv @@
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module vogp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/voxel_to_occupancy_grid_projection.sv @@
// ============================================================================
// Voxel to occupancy grid projection
// Projects voxels onto a 2D occupancy grid held in a cell RAM, with start,
// voxel and read words on one input channel and one result word per item.
// ============================================================================
// The block handles one input word at a time and returns exactly one result
// word for it. A voxel word that gets marked passes through check, address
// multiply, RAM read and write-back, and result; a read word skips the
// address multiply; a voxel dropped by the height band, the window or an
// invalid configuration goes from the check straight to the result. These
// steps follow the single read-modify-write path through the cell RAM, whose
// read data is registered. A start word returns its result at once and then
// sweeps the cell RAM, writing one cell per cycle, so no further word is
// accepted until the sweep ends. The same clearing pass (to unknown) runs
// after reset. Configuration writes are taken at any time, the sweeps
// included; the cell value a start clears to is captured when the start word
// is processed.
`include "voxel_to_occupancy_grid_projection_defines.svh"

module voxel_to_occupancy_grid_projection #(
    parameter int CELL_CAPACITY = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_wen,
    input  logic [2:0]         cfg_index,
    input  logic [16:0]        cfg_wdata,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [15:0] cell_x,
    input  logic signed [15:0] cell_y,
    input  logic signed [15:0] cell_z,
    input  logic [11:0]        read_index,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [7:0]  cell_value,
    output logic [12:0]        occupied_total,
    output logic [1:0]         status
);

    import vogp_pkg::*;

    localparam int AW = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    // Wide enough for any cell index the grid math can form and for the capacity.
    localparam logic [26:0] CAP_W      = 27'(CELL_CAPACITY);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELL_CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_ADDR,
        S_READ,
        S_RESP,
        S_CLEAR
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] origin_x_reg;
    logic signed [15:0] origin_y_reg;
    logic [12:0]        grid_width_reg;
    logic [12:0]        grid_height_reg;
    logic signed [16:0] z_low_reg;
    logic signed [16:0] z_high_reg;
    logic [1:0]         z_mode_reg;
    logic               unknown_def_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= 16'sd0;
            origin_y_reg    <= 16'sd0;
            grid_width_reg  <= 13'd64;
            grid_height_reg <= 13'd64;
            z_low_reg       <= 17'sd0;
            z_high_reg      <= 17'sd0;
            z_mode_reg      <= 2'd0;
            unknown_def_reg <= 1'b1;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:    origin_x_reg    <= cfg_wdata[15:0];
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata[15:0];
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[12:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[12:0];
                REG_Z_LOW:       z_low_reg       <= cfg_wdata;
                REG_Z_HIGH:      z_high_reg      <= cfg_wdata;
                REG_Z_MODE:      z_mode_reg      <= cfg_wdata[1:0];
                REG_UNKNOWN_DEF: unknown_def_reg <= cfg_wdata[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control and item registers
    // ------------------------------------------------------------------
    state_t             st_reg;
    logic               clr_pend_reg;
    logic [1:0]         clear_code_reg;
    logic [AW-1:0]      sweep_reg;
    logic [12:0]        occ_cnt_reg;
    logic               out_valid_reg;

    logic [1:0]         func_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic signed [15:0] z_reg;
    logic [11:0]        rd_idx_reg;
    logic [12:0]        dx_reg;
    logic [12:0]        dy_reg;
    logic [AW-1:0]      addr_reg;
    logic               hit_reg;
    logic signed [7:0]  res_value_reg;
    logic [1:0]         res_status_reg;
    logic signed [7:0]  out_value_reg;
    logic [12:0]        out_total_reg;
    logic [1:0]         out_status_reg;

    // ------------------------------------------------------------------
    // Checks on the held word (CALC) and cell index (ADDR)
    // ------------------------------------------------------------------
    logic [25:0]        grid_area;
    logic               cfg_ok;
    logic signed [16:0] centre;
    logic               height_fail;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               window_out;
    logic               rd_in_range;
    logic [26:0]        cell_idx;
    logic               in_accept;
    logic               out_load;

    assign grid_area = grid_width_reg * grid_height_reg;
    assign cfg_ok    = (grid_width_reg != 13'd0) && (grid_height_reg != 13'd0)
                    && ({1'b0, grid_area} <= CAP_W)
                    && !((z_mode_reg == 2'b11) && (z_high_reg < z_low_reg));

    // Voxel centre height in half-cell units: 2*z+1.
    assign centre      = {z_reg, 1'b1};
    assign height_fail = (z_mode_reg[0] && (centre < z_low_reg))
                      || (z_mode_reg[1] && (centre > z_high_reg));

    assign dx = $signed({x_reg[15], x_reg}) - $signed({origin_x_reg[15], origin_x_reg});
    assign dy = $signed({y_reg[15], y_reg}) - $signed({origin_y_reg[15], origin_y_reg});
    assign window_out = (dx < 17'sd0) || (dy < 17'sd0)
                     || (dx >= $signed({4'b0, grid_width_reg}))
                     || (dy >= $signed({4'b0, grid_height_reg}));

    assign rd_in_range = ({15'b0, rd_idx_reg} < CAP_W);

    // Row-major cell index: dy*grid_width + dx.
    assign cell_idx = 27'(dy_reg * grid_width_reg) + {14'b0, dx_reg};

    assign in_accept = in_valid && in_ready;
    assign out_load  = (st_reg == S_RESP) && (!out_valid_reg || out_ready);

    // ------------------------------------------------------------------
    // Cell RAM
    // ------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [1:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [1:0]    ram_rdata;

    assign ram_re    = ((st_reg == S_CALC) && (func_reg == FUNC_READ)) || (st_reg == S_ADDR);
    assign ram_raddr = (st_reg == S_CALC) ? AW'(rd_idx_reg) : AW'(cell_idx);
    assign ram_we    = (st_reg == S_CLEAR)
                    || ((st_reg == S_READ) && (func_reg == FUNC_VOXEL) && hit_reg);
    assign ram_waddr = (st_reg == S_CLEAR) ? sweep_reg : addr_reg;
    assign ram_wdata = (st_reg == S_CLEAR) ? clear_code_reg : CODE_OCC;

    vogp_ram #(
        .WIDTH (2),
        .DEPTH (CELL_CAPACITY)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // State machine, occupied count, sweep and result valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_CLEAR;
            clr_pend_reg   <= 1'b0;
            clear_code_reg <= CODE_UNKNOWN;
            sweep_reg      <= '0;
            occ_cnt_reg    <= 13'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Raise valid on a new load; drop it once the word is taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (st_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        st_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    unique case (func_reg)
                        FUNC_START:
                        begin
                            occ_cnt_reg    <= 13'd0;
                            clear_code_reg <= unknown_def_reg ? CODE_UNKNOWN : CODE_FREE;
                            clr_pend_reg   <= 1'b1;
                            st_reg         <= S_RESP;
                        end
                        FUNC_VOXEL:
                        begin
                            if (!cfg_ok || height_fail || window_out)
                            begin
                                st_reg <= S_RESP;
                            end
                            else
                            begin
                                st_reg <= S_ADDR;
                            end
                        end
                        FUNC_READ:
                        begin
                            st_reg <= S_READ;
                        end
                        FUNC_NONE:
                        begin
                            st_reg <= S_RESP;
                        end
                    endcase
                end
                S_ADDR:
                begin
                    st_reg <= S_READ;
                end
                S_READ:
                begin
                    // Count a cell only the first time it turns occupied.
                    if ((func_reg == FUNC_VOXEL) && hit_reg && (ram_rdata != CODE_OCC)
                        && (occ_cnt_reg != COUNT_MAX))
                    begin
                        occ_cnt_reg <= occ_cnt_reg + 13'd1;
                    end
                    st_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (out_load)
                    begin
                        clr_pend_reg  <= 1'b0;
                        st_reg        <= clr_pend_reg ? S_CLEAR : S_IDLE;
                    end
                end
                S_CLEAR:
                begin
                    if (sweep_reg == LAST_CELL)
                    begin
                        sweep_reg <= '0;
                        st_reg    <= S_IDLE;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + AW'(1);
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Item payload, pending result and output word
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg   <= func;
            x_reg      <= cell_x;
            y_reg      <= cell_y;
            z_reg      <= cell_z;
            rd_idx_reg <= read_index;
        end

        if (st_reg == S_CALC)
        begin
            dx_reg        <= dx[12:0];
            dy_reg        <= dy[12:0];
            addr_reg      <= AW'(rd_idx_reg);
            hit_reg       <= rd_in_range;
            unique case (func_reg)
                FUNC_START:
                begin
                    res_value_reg  <= unknown_def_reg ? VAL_UNKNOWN : VAL_FREE;
                    res_status_reg <= cfg_ok ? ST_OK : ST_INVALID;
                end
                FUNC_VOXEL:
                begin
                    res_value_reg <= VAL_FREE;
                    if (!cfg_ok)
                    begin
                        res_status_reg <= ST_INVALID;
                    end
                    else if (height_fail)
                    begin
                        res_status_reg <= ST_HEIGHT;
                    end
                    else if (window_out)
                    begin
                        res_status_reg <= ST_WINDOW;
                    end
                    else
                    begin
                        res_status_reg <= ST_OK;
                    end
                end
                FUNC_READ:
                begin
                    res_value_reg  <= VAL_FREE;
                    res_status_reg <= cfg_ok ? ST_OK : ST_INVALID;
                end
                FUNC_NONE:
                begin
                    res_value_reg  <= VAL_FREE;
                    res_status_reg <= ST_OK;
                end
            endcase
        end

        if (st_reg == S_ADDR)
        begin
            addr_reg <= AW'(cell_idx);
            hit_reg  <= (cell_idx < CAP_W);
        end

        if (st_reg == S_READ)
        begin
            if (func_reg == FUNC_VOXEL)
            begin
                res_value_reg <= VAL_OCC;
            end
            else
            begin
                res_value_reg <= hit_reg ? code_to_value(ram_rdata) : VAL_UNKNOWN;
            end
        end

        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_total_reg  <= occ_cnt_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign in_ready       = (st_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign cell_value     = out_value_reg;
    assign occupied_total = out_total_reg;
    assign status         = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `VOGP_ASSERT_NOW(a_no_write_on_accept, clk, rst_n, in_accept, !ram_we,
        "cell RAM written while a word is accepted")

    `VOGP_ASSERT_NOW(a_mark_only_outside_sweep, clk, rst_n,
        ram_we && (st_reg != S_CLEAR), ram_wdata == CODE_OCC,
        "non-occupied write outside the clearing sweep")

    `VOGP_ASSERT_NEXT(a_read_lands_in_read, clk, rst_n, ram_re, st_reg == S_READ,
        "RAM read data not consumed in the following cycle")

    `VOGP_ASSERT_NEXT(a_count_steps_by_one, clk, rst_n, st_reg != S_CALC,
        (occ_cnt_reg == $past(occ_cnt_reg)) || (occ_cnt_reg == $past(occ_cnt_reg) + 13'd1),
        "occupied count moved by more than one outside a start")

endmodule
